FILE: design/assert_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: design/spp_pkg.sv
package spp_pkg;

  localparam int COEF_W   = 16;
  localparam int COORD_W  = 24;
  localparam int DIFF_W   = 25;
  localparam int PROD_W   = 41;
  localparam int SUM_W    = 43;
  localparam int ACROSS_W = 26;
  localparam int DEPTH_W  = 25;
  localparam int EAR_W    = 27;
  localparam int SQ_W     = 54;
  localparam int DSQ_W    = 50;
  localparam int D2_W     = 55;
  localparam int RAD_W    = 24;
  localparam int ROOT_W   = 12;
  localparam int REM_W    = 14;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int GAIN_W   = 8;
  localparam int VOL_W    = 8;
  localparam int SND_W    = 8;
  localparam int BUFNUM_W = 9;
  localparam int RATE_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int RECIP_W  = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ACROSS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ACROSS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ACROSS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_DEPTH_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_DEPTH_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_DEPTH_Z  = 3'd5;

  localparam logic signed [COEF_W-1:0] ROT_ONE  = 16'sd4096;
  localparam logic signed [COEF_W-1:0] ROT_ZERO = 16'sd0;

  // rounding bias so that the arithmetic shift truncates toward zero
  localparam logic signed [SUM_W-1:0] ACROSS_BIAS = 43'sd131071;
  localparam logic signed [SUM_W-1:0] DEPTH_BIAS  = 43'sd262143;
  localparam logic signed [EAR_W-1:0] EAR_OFFSET  = 27'sd1024;

  // d^2 at or above 0xc00^2 means d >= 0xc00, and the gain is zero
  localparam logic [D2_W-1:0]    FAR_LIMIT = 55'h900000;
  localparam logic [ROOT_W-1:0]  GAIN_BASE = 12'hc00;
  localparam logic [RECIP_W-1:0] RECIP3    = 19'd683;
  localparam logic [GAIN_W:0]    GAIN_FULL = 9'd128;

  typedef struct packed {
    logic signed [COEF_W-1:0] ax;
    logic signed [COEF_W-1:0] ay;
    logic signed [COEF_W-1:0] az;
    logic signed [COEF_W-1:0] dx;
    logic signed [COEF_W-1:0] dy;
    logic signed [COEF_W-1:0] dz;
  } rot_cfg_t;

  typedef struct packed {
    logic [VOL_W-1:0]  vol;
    logic [SND_W-1:0]  snd;
    logic [RATE_W-1:0] rate;
  } side_t;

  typedef struct packed {
    logic              far;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } ear_t;

  typedef struct packed {
    ear_t  l;
    ear_t  r;
    side_t side;
  } tok_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   left_gain;
    logic [GAIN_W-1:0]   right_gain;
    logic [GAIN_W-1:0]   mean_gain;
    logic [BUFNUM_W-1:0] buffer_number;
    logic [RATE_W-1:0]   rate;
  } res_t;

endpackage

FILE: design/spp_front.sv
module spp_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [spp_pkg::COORD_W-1:0]  source_x,
  input  logic signed [spp_pkg::COORD_W-1:0]  source_y,
  input  logic signed [spp_pkg::COORD_W-1:0]  source_z,
  input  logic signed [spp_pkg::COORD_W-1:0]  listener_x,
  input  logic signed [spp_pkg::COORD_W-1:0]  listener_y,
  input  logic signed [spp_pkg::COORD_W-1:0]  listener_z,
  input  logic        [spp_pkg::VOL_W-1:0]    loudness,
  input  logic        [spp_pkg::SND_W-1:0]    sound_number,
  input  logic        [spp_pkg::RATE_W-1:0]   rate_in,
  input  spp_pkg::rot_cfg_t                   rot,
  output logic                                out_valid,
  output spp_pkg::tok_t                       out_tok
);

  logic v1, v2, v3, v4, v5;
  spp_pkg::side_t s1, s2, s3, s4, s5;

  logic signed [spp_pkg::DIFF_W-1:0] dx, dy, dz;
  logic signed [spp_pkg::PROD_W-1:0] pax, pay, paz, pdx, pdy, pdz;
  logic signed [spp_pkg::ACROSS_W-1:0] across;
  logic signed [spp_pkg::DEPTH_W-1:0]  depth;
  logic signed [spp_pkg::EAR_W-1:0]    ear_l, ear_r;
  logic signed [spp_pkg::DEPTH_W-1:0]  depth4;
  logic signed [spp_pkg::SQ_W-1:0]     sq_l, sq_r;
  logic signed [spp_pkg::DSQ_W-1:0]    sq_d;

  logic signed [spp_pkg::SUM_W-1:0] sum_a, sum_d, adj_a, adj_d;
  logic [spp_pkg::D2_W-1:0] d2_l, d2_r;
  logic far_l, far_r;

  always_comb begin
    sum_a = spp_pkg::SUM_W'(pax) + spp_pkg::SUM_W'(pay) + spp_pkg::SUM_W'(paz);
    sum_d = spp_pkg::SUM_W'(pdx) + spp_pkg::SUM_W'(pdy) + spp_pkg::SUM_W'(pdz);
    adj_a = sum_a + (sum_a[spp_pkg::SUM_W-1] ? spp_pkg::ACROSS_BIAS : '0);
    adj_d = sum_d + (sum_d[spp_pkg::SUM_W-1] ? spp_pkg::DEPTH_BIAS : '0);
    d2_l = spp_pkg::D2_W'($unsigned(sq_l)) + spp_pkg::D2_W'($unsigned(sq_d));
    d2_r = spp_pkg::D2_W'($unsigned(sq_r)) + spp_pkg::D2_W'($unsigned(sq_d));
    far_l = (d2_l >= spp_pkg::FAR_LIMIT);
    far_r = (d2_r >= spp_pkg::FAR_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= spp_pkg::DIFF_W'(source_x) - spp_pkg::DIFF_W'(listener_x);
      dy <= spp_pkg::DIFF_W'(source_y) - spp_pkg::DIFF_W'(listener_y);
      dz <= spp_pkg::DIFF_W'(source_z) - spp_pkg::DIFF_W'(listener_z);
      s1 <= '{vol: loudness, snd: sound_number, rate: rate_in};

      pax <= spp_pkg::PROD_W'(dx) * spp_pkg::PROD_W'(rot.ax);
      pay <= spp_pkg::PROD_W'(dy) * spp_pkg::PROD_W'(rot.ay);
      paz <= spp_pkg::PROD_W'(dz) * spp_pkg::PROD_W'(rot.az);
      pdx <= spp_pkg::PROD_W'(dx) * spp_pkg::PROD_W'(rot.dx);
      pdy <= spp_pkg::PROD_W'(dy) * spp_pkg::PROD_W'(rot.dy);
      pdz <= spp_pkg::PROD_W'(dz) * spp_pkg::PROD_W'(rot.dz);
      s2 <= s1;

      across <= adj_a[spp_pkg::SUM_W-1 -: spp_pkg::ACROSS_W];
      depth  <= adj_d[spp_pkg::SUM_W-1 -: spp_pkg::DEPTH_W];
      s3 <= s2;

      ear_l  <= spp_pkg::EAR_W'(across) + spp_pkg::EAR_OFFSET;
      ear_r  <= spp_pkg::EAR_W'(across) - spp_pkg::EAR_OFFSET;
      depth4 <= depth;
      s4 <= s3;

      sq_l <= spp_pkg::SQ_W'(ear_l) * spp_pkg::SQ_W'(ear_l);
      sq_r <= spp_pkg::SQ_W'(ear_r) * spp_pkg::SQ_W'(ear_r);
      sq_d <= spp_pkg::DSQ_W'(depth4) * spp_pkg::DSQ_W'(depth4);
      s5 <= s4;

      out_tok.l.far  <= far_l;
      out_tok.l.rad  <= far_l ? '0 : d2_l[spp_pkg::RAD_W-1:0];
      out_tok.l.rem  <= '0;
      out_tok.l.root <= '0;
      out_tok.r.far  <= far_r;
      out_tok.r.rad  <= far_r ? '0 : d2_r[spp_pkg::RAD_W-1:0];
      out_tok.r.rem  <= '0;
      out_tok.r.root <= '0;
      out_tok.side   <= s5;
    end
  end

endmodule

FILE: design/spp_cell.sv
module spp_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  spp_pkg::tok_t in_tok,
  output logic          out_valid,
  output spp_pkg::tok_t out_tok
);

  // one root bit per cell: bring down two radicand bits, try 4*root+1
  function automatic spp_pkg::ear_t root_step(input spp_pkg::ear_t e);
    logic [spp_pkg::REM_W+1:0] rem_sh;
    logic [spp_pkg::REM_W+1:0] trial;
    spp_pkg::ear_t o;
    rem_sh = {e.rem, e.rad[spp_pkg::RAD_W-1 -: 2]};
    trial  = (spp_pkg::REM_W+2)'({e.root, 2'b01});
    o.far  = e.far;
    o.rad  = {e.rad[spp_pkg::RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      o.rem  = spp_pkg::REM_W'(rem_sh - trial);
      o.root = {e.root[spp_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem_sh[spp_pkg::REM_W-1:0];
      o.root = {e.root[spp_pkg::ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tok.l    <= root_step(in_tok.l);
      out_tok.r    <= root_step(in_tok.r);
      out_tok.side <= in_tok.side;
    end
  end

endmodule

FILE: design/spp_gain.sv
module spp_gain (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  spp_pkg::tok_t in_tok,
  output logic          out_valid,
  output spp_pkg::res_t out_res
);

  logic v1;
  logic far_l, far_r;
  logic [spp_pkg::GAIN_W-1:0] q_l, q_r;
  spp_pkg::side_t s1;

  logic [spp_pkg::ROOT_W-1:0]  span_l, span_r;
  logic [spp_pkg::RECIP_W-1:0] m_l, m_r;
  logic [2*spp_pkg::GAIN_W-1:0] p_l, p_r;
  logic [spp_pkg::GAIN_W:0] raw_l, raw_r;
  logic [spp_pkg::GAIN_W-1:0] g_l, g_r;
  logic [spp_pkg::GAIN_W:0] g_sum;

  // (0xc00 - d) / 24 as ((0xc00 - d) >> 3) / 3, the /3 by reciprocal
  always_comb begin
    span_l = spp_pkg::GAIN_BASE - in_tok.l.root;
    span_r = spp_pkg::GAIN_BASE - in_tok.r.root;
    m_l = spp_pkg::RECIP_W'(span_l[spp_pkg::ROOT_W-1:3]) * spp_pkg::RECIP3;
    m_r = spp_pkg::RECIP_W'(span_r[spp_pkg::ROOT_W-1:3]) * spp_pkg::RECIP3;
  end

  always_comb begin
    p_l = (2*spp_pkg::GAIN_W)'(q_l) * (2*spp_pkg::GAIN_W)'(s1.vol);
    p_r = (2*spp_pkg::GAIN_W)'(q_r) * (2*spp_pkg::GAIN_W)'(s1.vol);
    raw_l = p_l[2*spp_pkg::GAIN_W-1:7];
    raw_r = p_r[2*spp_pkg::GAIN_W-1:7];
    if (far_l) begin
      g_l = '0;
    end else if (raw_l > spp_pkg::GAIN_FULL) begin
      g_l = spp_pkg::GAIN_FULL[spp_pkg::GAIN_W-1:0];
    end else begin
      g_l = raw_l[spp_pkg::GAIN_W-1:0];
    end
    if (far_r) begin
      g_r = '0;
    end else if (raw_r > spp_pkg::GAIN_FULL) begin
      g_r = spp_pkg::GAIN_FULL[spp_pkg::GAIN_W-1:0];
    end else begin
      g_r = raw_r[spp_pkg::GAIN_W-1:0];
    end
    g_sum = (spp_pkg::GAIN_W+1)'(g_l) + (spp_pkg::GAIN_W+1)'(g_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_l   <= m_l[spp_pkg::RECIP_W-1:11];
      q_r   <= m_r[spp_pkg::RECIP_W-1:11];
      far_l <= in_tok.l.far;
      far_r <= in_tok.r.far;
      s1    <= in_tok.side;

      out_res.left_gain     <= g_l;
      out_res.right_gain    <= g_r;
      out_res.mean_gain     <= g_sum[spp_pkg::GAIN_W:1];
      out_res.buffer_number <= spp_pkg::BUFNUM_W'(s1.snd) + spp_pkg::BUFNUM_W'(1);
      out_res.rate          <= s1.rate;
    end
  end

endmodule

FILE: design/stereo_pan_from_position_top.sv
// Stages from input transfer to out_valid: 6 front stages, 12 square-root
// cells, 2 gain stages, 1 output register.
// Throughput: one item per cycle while the skid register is empty; a skid
// register lets one more item in while a result waits on out_ready.
// Reset (rst, synchronous): empties the pipeline and restores the rotation rows.
`include "assert_macros.svh"

module stereo_pan_from_position_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [spp_pkg::COORD_W-1:0]     source_x,
  input  logic signed [spp_pkg::COORD_W-1:0]     source_y,
  input  logic signed [spp_pkg::COORD_W-1:0]     source_z,
  input  logic signed [spp_pkg::COORD_W-1:0]     listener_x,
  input  logic signed [spp_pkg::COORD_W-1:0]     listener_y,
  input  logic signed [spp_pkg::COORD_W-1:0]     listener_z,
  input  logic        [spp_pkg::VOL_W-1:0]       loudness,
  input  logic        [spp_pkg::SND_W-1:0]       sound_number,
  input  logic        [spp_pkg::RATE_W-1:0]      rate_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [spp_pkg::GAIN_W-1:0]      left_gain,
  output logic        [spp_pkg::GAIN_W-1:0]      right_gain,
  output logic        [spp_pkg::GAIN_W-1:0]      mean_gain,
  output logic        [spp_pkg::BUFNUM_W-1:0]    buffer_number,
  output logic        [spp_pkg::RATE_W-1:0]      rate_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [spp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [spp_pkg::COEF_W-1:0]      cfg_data
);

  spp_pkg::rot_cfg_t rot;
  logic pipe_en;

  logic          chain_valid [0:spp_pkg::SQRT_STEPS];
  spp_pkg::tok_t chain_tok   [0:spp_pkg::SQRT_STEPS];

  logic          pipe_valid;
  spp_pkg::res_t pipe_res;
  logic          skid_valid;
  spp_pkg::res_t skid_res;
  spp_pkg::res_t out_res;

  assign cfg_ready = 1'b1;
  assign pipe_en   = !skid_valid;
  assign in_ready  = pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot.ax <= spp_pkg::ROT_ONE;
      rot.ay <= spp_pkg::ROT_ZERO;
      rot.az <= spp_pkg::ROT_ZERO;
      rot.dx <= spp_pkg::ROT_ZERO;
      rot.dy <= spp_pkg::ROT_ZERO;
      rot.dz <= spp_pkg::ROT_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spp_pkg::CFG_ROT_ACROSS_X: rot.ax <= cfg_data;
        spp_pkg::CFG_ROT_ACROSS_Y: rot.ay <= cfg_data;
        spp_pkg::CFG_ROT_ACROSS_Z: rot.az <= cfg_data;
        spp_pkg::CFG_ROT_DEPTH_X:  rot.dx <= cfg_data;
        spp_pkg::CFG_ROT_DEPTH_Y:  rot.dy <= cfg_data;
        spp_pkg::CFG_ROT_DEPTH_Z:  rot.dz <= cfg_data;
        default: ;
      endcase
    end
  end

  spp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (pipe_en),
    .in_valid     (in_valid),
    .source_x     (source_x),
    .source_y     (source_y),
    .source_z     (source_z),
    .listener_x   (listener_x),
    .listener_y   (listener_y),
    .listener_z   (listener_z),
    .loudness     (loudness),
    .sound_number (sound_number),
    .rate_in      (rate_in),
    .rot          (rot),
    .out_valid    (chain_valid[0]),
    .out_tok      (chain_tok[0])
  );

  for (genvar i = 0; i < spp_pkg::SQRT_STEPS; i++) begin : g_cell
    spp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (pipe_en),
      .in_valid  (chain_valid[i]),
      .in_tok    (chain_tok[i]),
      .out_valid (chain_valid[i+1]),
      .out_tok   (chain_tok[i+1])
    );
  end

  spp_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (chain_valid[spp_pkg::SQRT_STEPS]),
    .in_tok    (chain_tok[spp_pkg::SQRT_STEPS]),
    .out_valid (pipe_valid),
    .out_res   (pipe_res)
  );

  // output register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= pipe_valid && pipe_en;
      end
    end else if (pipe_valid && pipe_en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_res <= skid_valid ? skid_res : pipe_res;
    end else if (pipe_valid && pipe_en) begin
      skid_res <= pipe_res;
    end
  end

  assign left_gain     = out_res.left_gain;
  assign right_gain    = out_res.right_gain;
  assign mean_gain     = out_res.mean_gain;
  assign buffer_number = out_res.buffer_number;
  assign rate_out      = out_res.rate;

  `ASSERT_CLK(a_gain_range, out_valid |-> (left_gain <= 8'd128 && right_gain <= 8'd128), "gain above full scale")
  `ASSERT_CLK(a_mean_match, out_valid |-> (mean_gain == 8'((9'(left_gain) + 9'(right_gain)) >> 1)), "mean gain mismatch")
  `ASSERT_NEVER(a_skid_alone, skid_valid && !out_valid, "skid holds data with output empty")
  `ASSERT_CLK(a_skid_fill, $rose(skid_valid) |-> $past(out_valid && !out_ready), "skid filled without stall")

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import spp_pkg::*;

  localparam int PHASES = 8;
  localparam int RANDOM_PER_PHASE = 112;
  localparam int PIPE_LATENCY = 21;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam longint EAR_SPAN = 'h400;
  localparam longint GAIN_TOP = 'hc00;
  localparam longint GAIN_STEP = 24;
  localparam longint FULL_SCALE = 128;
  localparam longint ROT_SCALE = 'h20000;

  typedef struct packed {
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic signed [COORD_W-1:0] src_z;
    logic signed [COORD_W-1:0] lst_x;
    logic signed [COORD_W-1:0] lst_y;
    logic signed [COORD_W-1:0] lst_z;
    logic [VOL_W-1:0]          loud;
    logic [SND_W-1:0]          snd;
    logic [RATE_W-1:0]         rate;
  } pan_event_t;

  typedef struct {
    pan_event_t ev;
    bit         known;
    res_t       want;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] source_x = '0;
  logic signed [COORD_W-1:0] source_y = '0;
  logic signed [COORD_W-1:0] source_z = '0;
  logic signed [COORD_W-1:0] listener_x = '0;
  logic signed [COORD_W-1:0] listener_y = '0;
  logic signed [COORD_W-1:0] listener_z = '0;
  logic [VOL_W-1:0] loudness = '0;
  logic [SND_W-1:0] sound_number = '0;
  logic [RATE_W-1:0] rate_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [GAIN_W-1:0] left_gain;
  logic [GAIN_W-1:0] right_gain;
  logic [GAIN_W-1:0] mean_gain;
  logic [BUFNUM_W-1:0] buffer_number;
  logic [RATE_W-1:0] rate_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  rot_cfg_t view_rot = '{ROT_ONE, ROT_ZERO, ROT_ZERO, ROT_ZERO, ROT_ZERO, ROT_ONE};
  res_t pending_gains[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int results_checked = 0;
  int events_sent = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  stereo_pan_from_position_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .source_x(source_x),
    .source_y(source_y),
    .source_z(source_z),
    .listener_x(listener_x),
    .listener_y(listener_y),
    .listener_z(listener_z),
    .loudness(loudness),
    .sound_number(sound_number),
    .rate_in(rate_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_gain(left_gain),
    .right_gain(right_gain),
    .mean_gain(mean_gain),
    .buffer_number(buffer_number),
    .rate_out(rate_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint isqrt_floor(longint n);
    longint root;
    longint trial;
    root = 0;
    for (int i = 29; i >= 0; i--) begin
      trial = root | (longint'(1) << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic [GAIN_W-1:0] ear_level(longint off, longint depth_sq, longint vol);
    longint g;
    g = ((GAIN_TOP - isqrt_floor(off * off + depth_sq)) / GAIN_STEP) * vol / FULL_SCALE;
    if (g < 0) g = 0;
    else if (g > FULL_SCALE) g = FULL_SCALE;
    return GAIN_W'(g);
  endfunction

  function automatic res_t predict_pan(pan_event_t ev);
    longint dx;
    longint dy;
    longint dz;
    longint across;
    longint depth;
    res_t r;
    dx = longint'($signed(ev.src_x)) - longint'($signed(ev.lst_x));
    dy = longint'($signed(ev.src_y)) - longint'($signed(ev.lst_y));
    dz = longint'($signed(ev.src_z)) - longint'($signed(ev.lst_z));
    across = (longint'($signed(view_rot.ax)) * dx + longint'($signed(view_rot.ay)) * dy +
              longint'($signed(view_rot.az)) * dz) / ROT_SCALE;
    depth = (longint'($signed(view_rot.dx)) * dx + longint'($signed(view_rot.dy)) * dy +
             longint'($signed(view_rot.dz)) * dz) / ROT_SCALE / 2;
    r.left_gain = ear_level(across + EAR_SPAN, depth * depth, longint'(ev.loud));
    r.right_gain = ear_level(across - EAR_SPAN, depth * depth, longint'(ev.loud));
    r.mean_gain = GAIN_W'((longint'(r.left_gain) + longint'(r.right_gain)) / 2);
    r.buffer_number = BUFNUM_W'(ev.snd) + BUFNUM_W'(1);
    r.rate = ev.rate;
    return r;
  endfunction

  function automatic dir_row_t row(longint sx, longint sy, longint sz, longint lx,
                                   longint ly, longint lz, int vol, int snd, int rate,
                                   bit known, int l, int r, int m);
    dir_row_t d;
    d.ev.src_x = COORD_W'(sx);
    d.ev.src_y = COORD_W'(sy);
    d.ev.src_z = COORD_W'(sz);
    d.ev.lst_x = COORD_W'(lx);
    d.ev.lst_y = COORD_W'(ly);
    d.ev.lst_z = COORD_W'(lz);
    d.ev.loud = VOL_W'(vol);
    d.ev.snd = SND_W'(snd);
    d.ev.rate = RATE_W'(rate);
    d.known = known;
    d.want.left_gain = GAIN_W'(l);
    d.want.right_gain = GAIN_W'(r);
    d.want.mean_gain = GAIN_W'(m);
    d.want.buffer_number = BUFNUM_W'(snd + 1);
    d.want.rate = RATE_W'(rate);
    return d;
  endfunction

  function automatic logic signed [COORD_W-1:0] jitter(int span_log2);
    int span;
    span = 1 << span_log2;
    return COORD_W'(int'($urandom_range(2 * span)) - span);
  endfunction

  // mostly sources near the listener so the gains land inside 0..128
  function automatic pan_event_t random_event();
    pan_event_t ev;
    int kind;
    int span_log2;
    kind = $urandom_range(99);
    ev.lst_x = COORD_W'($urandom);
    ev.lst_y = COORD_W'($urandom);
    ev.lst_z = COORD_W'($urandom);
    if (kind < 15) begin
      ev.src_x = COORD_W'($urandom);
      ev.src_y = COORD_W'($urandom);
      ev.src_z = COORD_W'($urandom);
    end else if (kind < 25) begin
      ev.src_x = ev.lst_x;
      ev.src_y = ev.lst_y;
      ev.src_z = ev.lst_z;
    end else begin
      span_log2 = $urandom_range(17, 2);
      ev.src_x = ev.lst_x + jitter(span_log2);
      ev.src_y = ev.lst_y + jitter(span_log2);
      ev.src_z = ev.lst_z + jitter(span_log2);
    end
    ev.loud = ($urandom_range(3) == 0) ? VOL_W'(FULL_SCALE) : VOL_W'($urandom_range(255));
    ev.snd = SND_W'($urandom_range(255));
    ev.rate = RATE_W'($urandom_range(65535));
    return ev;
  endfunction

  task automatic send_event(input pan_event_t ev, input bit known, input res_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    source_x <= ev.src_x;
    source_y <= ev.src_y;
    source_z <= ev.src_z;
    listener_x <= ev.lst_x;
    listener_y <= ev.lst_y;
    listener_z <= ev.lst_z;
    loudness <= ev.loud;
    sound_number <= ev.snd;
    rate_in <= ev.rate;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_gains.push_back(known ? want : predict_pan(ev));
    events_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ROT_ACROSS_X: view_rot.ax = val;
      CFG_ROT_ACROSS_Y: view_rot.ay = val;
      CFG_ROT_ACROSS_Z: view_rot.az = val;
      CFG_ROT_DEPTH_X:  view_rot.dx = val;
      CFG_ROT_DEPTH_Y:  view_rot.dy = val;
      CFG_ROT_DEPTH_Z:  view_rot.dz = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{left_gain, right_gain, mean_gain, buffer_number, rate_out};
      if (pending_gains.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected transfer L=%0d R=%0d M=%0d buf=%0d rate=%0d", $time,
                   got.left_gain, got.right_gain, got.mean_gain, got.buffer_number, got.rate);
      end else begin
        want = pending_gains.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: result %0d expected L/R/M=%0d/%0d/%0d buf=%0d rate=%0d",
                     $time, results_checked, want.left_gain, want.right_gain,
                     want.mean_gain, want.buffer_number, want.rate,
                     "  got L/R/M=%0d/%0d/%0d buf=%0d rate=%0d", got.left_gain,
                     got.right_gain, got.mean_gain, got.buffer_number, got.rate);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding", STALL_LIMIT,
               pending_gains.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rot_cfg_t next_rot;
    dir_row_t directed_q[$];
    // zero offset: both ears at 0x400, gain 85 at full scale
    directed_q.push_back(row(0, 0, 0, 0, 0, 0, 128, 0, 0, 1, 85, 85, 85));
    directed_q.push_back(row(8388607, -8388608, 8388607, 8388607, -8388608, 8388607,
                             255, 255, 65535, 1, 128, 128, 128));
    directed_q.push_back(row(0, 0, 0, 0, 0, 0, 0, 7, 'h1234, 1, 0, 0, 0));
    directed_q.push_back(row(0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 0, 0, 0));
    directed_q.push_back(row(0, 0, 0, 0, 0, 0, 64, 2, 2, 1, 42, 42, 42));
    // far away along one axis (x or z): gain term negative
    directed_q.push_back(row(8388607, 0, 0, -8388608, 0, 0, 255, 'h80, 'h8000, 1, 0, 0, 0));
    directed_q.push_back(row(-8388608, 0, 0, 8388607, 0, 0, 255, 'h7f, 'h7fff, 1, 0, 0, 0));
    directed_q.push_back(row(0, 0, -8388608, 0, 0, 8388607, 128, 'h55, 'haaaa, 1, 0, 0, 0));
    // y has zero weight in the reset rotation
    directed_q.push_back(row(0, 8388607, 0, 0, -8388608, 0, 128, 'haa, 'h5555, 1, 85, 85, 85));
    directed_q.push_back(row(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                             128, 9, 'hffff, 1, 85, 85, 85));
    // source on an ear, and on the zero-gain radius
    directed_q.push_back(row(-32768, 0, 0, 0, 0, 0, 128, 3, 100, 1, 128, 42, 85));
    directed_q.push_back(row(32768, 0, 0, 0, 0, 0, 128, 4, 200, 1, 42, 128, 85));
    directed_q.push_back(row(65536, 0, 0, 0, 0, 0, 128, 5, 300, 1, 0, 85, 42));
    directed_q.push_back(row(65535, 0, 0, 0, 0, 0, 128, 6, 400, 0, 0, 0, 0));
    directed_q.push_back(row(-32768, 0, 0, 0, 0, 0, 129, 10, 500, 0, 0, 0, 0));
    directed_q.push_back(row(-32768, 0, 0, 0, 0, 0, 255, 11, 600, 0, 0, 0, 0));
    // small negative offsets truncate toward zero
    directed_q.push_back(row(-1, 0, -63, 0, 0, 0, 200, 12, 700, 0, 0, 0, 0));
    directed_q.push_back(row(1000, -2000, 30000, 0, 0, 0, 100, 13, 800, 0, 0, 0, 0));
    directed_q.push_back(row(-50000, 7, -90000, 12345, -6789, 1000, 77, 14, 900, 0, 0, 0, 0));
    directed_q.push_back(row(5000000, 5000000, 5000000, 5020000, 5000000, 4990000,
                             255, 15, 1000, 0, 0, 0, 0));
    directed_q.push_back(row(-100, 0, 100000, 0, 0, 0, 180, 16, 1100, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_q[i])
      send_event(directed_q[i].ev, directed_q[i].known, directed_q[i].want);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 71;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 71;
        end
        default: begin
          idle_pct = 9;
          stall_pct = 9;
        end
      endcase
      case (p)
        0: next_rot = '{ROT_ONE, ROT_ZERO, ROT_ZERO, ROT_ZERO, ROT_ZERO, ROT_ONE};
        1: next_rot = '{6{16'sh7fff}};
        2: next_rot = '{6{16'sh8000}};
        3: next_rot = '{ROT_ZERO, ROT_ONE, ROT_ZERO, -ROT_ONE, ROT_ZERO, ROT_ZERO};
        4: next_rot = '{COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                        COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom)};
        5: next_rot = '{16'sh7fff, 16'sh8000, ROT_ZERO, 16'sh8000, ROT_ZERO, 16'sh7fff};
        6: next_rot = '{16'sd2896, ROT_ZERO, -16'sd2896, 16'sd2896, ROT_ZERO, 16'sd2896};
        default: next_rot = '{-ROT_ONE, ROT_ZERO, ROT_ZERO, ROT_ZERO, ROT_ZERO, -ROT_ONE};
      endcase
      write_reg(CFG_ROT_ACROSS_X, next_rot.ax);
      write_reg(CFG_ROT_ACROSS_Y, next_rot.ay);
      write_reg(CFG_ROT_ACROSS_Z, next_rot.az);
      write_reg(CFG_ROT_DEPTH_X, next_rot.dx);
      write_reg(CFG_ROT_DEPTH_Y, next_rot.dy);
      write_reg(CFG_ROT_DEPTH_Z, next_rot.dz);
      // unmapped indexes must leave the rotation alone
      if (p % 4 == 0) begin
        write_reg(CFG_SPARE_LO, COEF_W'($urandom));
        write_reg(CFG_SPARE_HI, COEF_W'($urandom));
      end
      cfg_valid <= 1'b0;
      repeat (RANDOM_PER_PHASE) send_event(random_event(), 1'b0, '0);
    end
    wait_drained();

    $display("Covered %0d sound events (%0d directed) over %0d rotation settings,",
             events_sent, directed_q.size(), PHASES + 1);
    $display("with and without stalls: %0d results checked, %0d register writes, %0d bad",
             results_checked, cfg_writes, mismatches);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: stereo_pan_from_position_top.f
+incdir+design
design/spp_pkg.sv
design/spp_front.sv
design/spp_cell.sv
design/spp_gain.sv
design/stereo_pan_from_position_top.sv
bench/testbench.sv
